>>> rtl/core/b58_pkg.sv
// Shared types, constants and the character classifier for the base-58 decoder.
// No dependencies.
package b58_pkg;

  localparam int unsigned Radix    = 58;
  localparam int unsigned DigitW   = 6;
  localparam int unsigned ValueW   = 64;
  localparam int unsigned ProdW    = 70;   // holds 58 * (2^64-1) + 57
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QIdxW    = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StInvalid  = 2'd1,
    StOverflow = 2'd2,
    StEmpty    = 2'd3
  } status_t;

  // One classified item on its way from front to back.
  typedef struct packed {
    logic              is_end;
    logic              bad;
    logic [DigitW-1:0] digit;
  } entry_t;

  // Queue flags seen by the front.
  typedef struct packed {
    logic full;
    logic empty;
  } qflags_t;

  // Map a byte to its digit; bad is set for bytes outside the alphabet.
  function automatic entry_t classify(input logic [7:0] c, input logic end_mark);
    entry_t e;
    logic [7:0] d;
    d = 8'd0;
    e.is_end = end_mark;
    e.bad    = 1'b0;
    if (c inside {[8'h31:8'h39]}) begin        // '1'..'9'
      d = c - 8'h31;
    end else if (c inside {[8'h41:8'h48]}) begin // 'A'..'H'
      d = c - 8'h41 + 8'd9;
    end else if (c inside {[8'h4A:8'h4E]}) begin // 'J'..'N'
      d = c - 8'h4A + 8'd17;
    end else if (c inside {[8'h50:8'h5A]}) begin // 'P'..'Z'
      d = c - 8'h50 + 8'd22;
    end else if (c inside {[8'h61:8'h6B]}) begin // 'a'..'k'
      d = c - 8'h61 + 8'd33;
    end else if (c inside {[8'h6D:8'h7A]}) begin // 'm'..'z'
      d = c - 8'h6D + 8'd44;
    end else begin
      e.bad = 1'b1;
    end
    e.digit = d[DigitW-1:0];
    return e;
  endfunction

endpackage

>>> rtl/core/b58_front.sv
// Front end: input handshake and character classification.
// Depends on b58_pkg.
module b58_front import b58_pkg::*; (
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  input  logic       is_end,
  input  qflags_t    qflags,
  output logic       push,
  output entry_t     push_entry
);

  assign in_ready   = !qflags.full;
  assign push       = in_valid && !qflags.full;
  assign push_entry = classify(char_code, is_end);

endmodule

>>> rtl/core/b58_queue.sv
// Short queue of classified items between front and back.
// Depends on b58_pkg.
module b58_queue import b58_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  entry_t  push_entry,
  input  logic    pop,
  output logic    head_valid,
  output entry_t  head,
  output qflags_t qflags
);

  entry_t             slots [QDepth];
  logic [QIdxW-1:0]   wr_ptr;
  logic [QIdxW-1:0]   rd_ptr;
  logic [QCntW-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign qflags.full  = (count == QCntW'(QDepth));
  assign qflags.empty = (count == '0);
  assign head_valid   = !qflags.empty;
  assign head         = slots[rd_ptr];
  assign do_push      = push && !qflags.full;
  assign do_pop       = pop && head_valid;

  function automatic logic [QIdxW-1:0] bump(input logic [QIdxW-1:0] p);
    return (p == QIdxW'(QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= bump(wr_ptr);
      if (do_pop)  rd_ptr <= bump(rd_ptr);
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_entry;
  end

endmodule

>>> rtl/core/b58_back.sv
// Back end: multiply-accumulate by 58, sticky error, result register.
// Depends on b58_pkg.
module b58_back import b58_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  entry_t            head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ValueW-1:0] value,
  output logic [1:0]        status
);

  logic [ValueW-1:0] acc;
  status_t           err;
  logic              seen;
  logic [ProdW-1:0]  prod;
  logic              slot_free;

  // acc*58 + digit as shift-add: 58 = 32 + 16 + 8 + 2
  assign prod = {1'b0, acc, 5'b0} + {2'b0, acc, 4'b0} + {3'b0, acc, 3'b0}
              + {5'b0, acc, 1'b0} + {{(ProdW-DigitW){1'b0}}, head.digit};

  assign slot_free = !out_valid || out_ready;
  assign pop       = head_valid && (!head.is_end || slot_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      err       <= StOk;
      seen      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop && head.is_end) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      if (pop) begin
        if (head.is_end) begin
          acc       <= '0;
          err       <= StOk;
          seen      <= 1'b0;
        end else begin
          seen <= 1'b1;
          if (err == StOk) begin
            if (head.bad) err <= StInvalid;
            else if (prod[ProdW-1:ValueW] != '0) err <= StOverflow;
            else acc <= prod[ValueW-1:0];
          end
        end
      end
    end
  end

  // Result payload, loaded with the terminator.
  always_ff @(posedge clk) begin
    if (pop && head.is_end) begin
      if (!seen) begin
        value  <= '0;
        status <= StEmpty;
      end else if (err != StOk) begin
        value  <= '0;
        status <= err;
      end else begin
        value  <= acc;
        status <= StOk;
      end
    end
  end

endmodule

>>> rtl/core/base58_u64_decoder.sv
// Top level of the base-58 to unsigned 64-bit decoder.
// Depends on b58_pkg, b58_front, b58_queue, b58_back.
//
//   channel | signals                              | transfer when
//   --------+--------------------------------------+------------------------
//   in      | in_valid, in_ready, char_code, is_end | in_valid && in_ready
//   out     | out_valid, out_ready, value, status   | out_valid && out_ready
//
// One item per cycle sustained while no held result stalls a terminator: the
// back end takes one queue entry each cycle, the times-58 step being a single
// shift-add with a carry check. A terminator's result passes through the queue
// write and then the back-end result register before it shows up.
// Synchronous reset (rst) empties the queue and clears acc and error status.
// A held result stalls only terminators; characters keep draining, and the
// input stalls once the two-entry queue is full.
module base58_u64_decoder import b58_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        char_code,
  input  logic              is_end,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ValueW-1:0] value,
  output logic [1:0]        status
);

  qflags_t qflags;
  logic    push;
  entry_t  push_entry;
  logic    pop;
  logic    head_valid;
  entry_t  head;

  // Classify each byte as it arrives.
  b58_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_code  (char_code),
    .is_end     (is_end),
    .qflags     (qflags),
    .push       (push),
    .push_entry (push_entry)
  );

  // Decouples the input from the result stall.
  b58_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .qflags     (qflags)
  );

  // Accumulate and report.
  b58_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .status     (status)
  );

endmodule

>>> rtl/core/b58_checker.sv
// Port-level checks for base58_u64_decoder, bound to the top level.
// Depends on b58_pkg.
module b58_checker import b58_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ValueW-1:0] value,
  input logic [1:0]        status
);

  // Held result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(status))
    else $error("result changed while stalled");

  // Any failing status reports a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != StOk |-> value == '0)
    else $error("nonzero value with error status");

  // No result right after reset.
  a_rst_out: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

  // Queue is empty after reset, so input is open.
  a_rst_in: assert property (@(posedge clk)
    $past(rst) |-> in_ready)
    else $error("input not ready after reset");

endmodule

bind base58_u64_decoder b58_checker u_b58_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .value     (value),
  .status    (status)
);

>>> bench/b58_decode_board_pkg.sv
// Decoded-value board for the base-58 decoder bench: predicts and checks results.
// Depends on b58_pkg for status_t.
package b58_decode_board_pkg;
  import b58_pkg::*;

  localparam string B58_ALPHABET =
    "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

  typedef struct packed {
    logic [63:0] value;
    status_t     status;
  } decoded_t;

  // Digit of a byte, or -1 when the byte is not in the alphabet.
  function automatic int b58_digit(logic [7:0] c);
    if (c >= 8'd128) return -1;
    for (int i = 0; i < 58; i++) begin
      if (B58_ALPHABET[i] == c) return i;
    end
    return -1;
  endfunction

  class decoded_value_board;
    logic [63:0] acc;
    status_t     err;
    bit          seen;
    decoded_t    expected_q[$];
    int          errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      acc  = '0;
      err  = StOk;
      seen = 1'b0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Accepted input transfer; a terminator queues one expected result.
    function void note_input(logic [7:0] c, logic e);
      decoded_t    r;
      logic [69:0] prod;
      int          d;
      if (e) begin
        r.value = '0;
        if (!seen) begin
          r.status = StEmpty;
        end else if (err != StOk) begin
          r.status = err;
        end else begin
          r.status = StOk;
          r.value  = acc;
        end
        expected_q.push_back(r);
        clear();
        return;
      end
      seen = 1'b1;
      if (err == StOk) begin
        d = b58_digit(c);
        if (d < 0) begin
          err = StInvalid;
        end else begin
          prod = 70'(acc) * 70'd58 + 70'(d);
          if (prod[69:64] != '0) err = StOverflow;
          else acc = prod[63:0];
        end
      end
    endfunction

    function void check_result(logic [63:0] v, logic [1:0] s);
      decoded_t x;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: value=%h status=%0d", v, s);
        return;
      end
      x = expected_q.pop_front();
      if (v !== x.value || s !== x.status) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                   x.value, x.status, v, s);
      end
    endfunction

    function bit clean();
      return errors == 0 && expected_q.size() == 0;
    endfunction
  endclass

endpackage

>>> bench/base58_u64_decoder_tb.sv
// Bench top for base58_u64_decoder: directed and random strings, random stalls.
// Depends on b58_pkg, b58_decode_board_pkg and the decoder RTL.
module base58_u64_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import b58_pkg::*;
  import b58_decode_board_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  char_code;
  logic        is_end;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] value;
  logic [1:0]  status;

  base58_u64_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .char_code (char_code),
    .is_end    (is_end),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .status    (status)
  );

  decoded_value_board board;

  logic [7:0] text[$];     // characters of the string being built
  int         items_sent;
  int         send_calm;   // remaining zero-gap transfers on the input side
  int         recv_calm;   // same, on the output side

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Random gap before a transfer, with occasional runs of back-to-back transfers.
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 19);
  endfunction

  function automatic logic [7:0] bad_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (b58_digit(c) >= 0);
    return c;
  endfunction

  function automatic logic [7:0] good_byte();
    return B58_ALPHABET[$urandom_range(0, 57)];
  endfunction

  // Append the base-58 spelling of v (no leading '1's but the lone '1' of zero) to the text.
  function automatic void append_encoded(logic [63:0] v);
    logic [7:0] digits[$];
    do begin
      digits.push_front(B58_ALPHABET[int'(v % 64'd58)]);
      v = v / 64'd58;
    end while (v != 0);
    text = {text, digits};
  endfunction

  // One input transfer. valid is only dropped when a gap is drawn, so a
  // back-to-back transfer never sees two assignments in one step.
  task automatic send_item(input logic [7:0] c, input logic e);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    is_end    <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_input(c, e);
    items_sent++;
  endtask

  // Send the built text followed by a terminator with a junk byte.
  task automatic send_text();
    foreach (text[i]) send_item(text[i], 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
    text.delete();
  endtask

  task automatic directed_strings();
    logic [63:0] max_v;
    logic [63:0] top;
    int          rem;
    max_v = '1;
    send_text();                              // empty string
    text.push_back("1"); send_text();         // lowest digit, value 0
    text.push_back("z"); send_text();         // highest digit
    text.push_back(8'h00); send_text();       // NUL is a plain bad byte
    text.push_back(8'hFF); send_text();       // top byte
    text.push_back(8'h80); send_text();       // just past ASCII
    text = {"0", "I", "O", "l"}; send_text(); // look-alikes left out of the set
    text = {"1", "1", "1", "2"}; send_text(); // leading zero digits
    append_encoded(max_v); send_text();       // all ones fits exactly
    // one past the top: max/58 followed by the digit just above max%58
    top = max_v / 64'd58;
    rem = int'(max_v % 64'd58);
    append_encoded(top);
    text.push_back(B58_ALPHABET[rem + 1]);
    send_text();
    // overflow first, then a bad byte: overflow sticks
    repeat (12) text.push_back("z");
    text.push_back("!");
    send_text();
    // bad byte first, then enough digits to overflow: invalid sticks
    text.push_back("0");
    repeat (12) text.push_back("z");
    send_text();
  endtask

  task automatic random_strings();
    int          kind;
    int          n;
    logic [63:0] v;
    while (items_sent < 1600) begin
      kind = $urandom_range(0, 99);
      if (kind < 82) begin
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) text.push_back("1");
        v = {32'($urandom), 32'($urandom)} >> $urandom_range(0, 63);
        append_encoded(v);
        if (kind >= 60 && kind < 70) begin
          // extra digits, which can carry the value past the 64-bit range
          repeat ($urandom_range(1, 3)) text.push_back(good_byte());
        end else if (kind >= 70) begin
          text.insert($urandom_range(0, text.size()), bad_byte());
        end
      end else if (kind < 88) begin
        // empty string
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) text.push_back(8'($urandom_range(0, 255)));
      end
      send_text();
    end
  endtask

  // Output side: random ready gaps, plus one long hold-off so that the
  // queue fills and the input stalls.
  initial begin : result_sink
    int gap;
    int results;
    results = 0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (results == 20) begin
        out_ready <= 1'b0;
        repeat (500) @(posedge clk);
        gap = 0;
      end else begin
        gap = draw_gap(recv_calm);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      board.check_result(value, status);
      results++;
    end
  end

  initial begin : stimulus
    board      = new();
    items_sent = 0;
    send_calm  = 0;
    recv_calm  = 0;
    rst        = 1'b1;
    in_valid   = 1'b0;
    char_code  = '0;
    is_end     = 1'b0;
    out_ready  = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_strings();
    random_strings();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.clean()) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Run limit, far above the slowest legal run.
  initial begin : watchdog
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/b58_pkg.sv
rtl/core/b58_front.sv
rtl/core/b58_queue.sv
rtl/core/b58_back.sv
rtl/core/base58_u64_decoder.sv
rtl/core/b58_checker.sv
bench/b58_decode_board_pkg.sv
bench/base58_u64_decoder_tb.sv
